// ===== src/ebm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ebm_pkg
// Shared types, codes and line tables of the serial EEPROM byte master.
// ----------------------------------------------------------------------------
package ebm_pkg;

  // default width of the slot and write-cycle counter
  localparam int WAIT_COUNTER_BITS_DEF = 24;

  // configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 24;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DEVICE_ADDRESS   = 2'd0,
    REG_QUARTER_TICKS    = 2'd1,
    REG_ACK_TIMEOUT      = 2'd2,
    REG_WRITE_WAIT_TICKS = 2'd3
  } reg_index_t;

  // register reset values
  localparam logic [6:0]  DEVICE_ADDRESS_RST   = 7'd80;
  localparam logic [15:0] QUARTER_TICKS_RST    = 16'd200;
  localparam logic [7:0]  ACK_TIMEOUT_RST      = 8'd250;
  localparam logic [23:0] WRITE_WAIT_TICKS_RST = 24'd1000000;

  // opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // byte stage within a transaction
  localparam logic [1:0] STAGE_DEVICE = 2'd0;
  localparam logic [1:0] STAGE_WORD   = 2'd1;
  localparam logic [1:0] STAGE_DATA   = 2'd2;
  localparam logic [1:0] STAGE_RECV   = 2'd3;

  // bits per byte on the bus
  localparam logic [3:0] BYTE_BITS = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_A   = 4'd1,
    PH_START_B   = 4'd2,
    PH_START_C   = 4'd3,
    PH_SEND_LOW  = 4'd4,
    PH_SEND_HIGH = 4'd5,
    PH_ACK_LOW   = 4'd6,
    PH_ACK_HIGH  = 4'd7,
    PH_RECV_LOW  = 4'd8,
    PH_RECV_HIGH = 4'd9,
    PH_NACK_LOW  = 4'd10,
    PH_NACK_HIGH = 4'd11,
    PH_STOP_A    = 4'd12,
    PH_STOP_B    = 4'd13,
    PH_STOP_C    = 4'd14,
    PH_WAIT      = 4'd15
  } phase_t;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [15:0] quarter_ticks;
    logic [7:0]  ack_timeout;
    logic [23:0] write_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] word_address;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_error;
  } out_item_t;

  // clock line level per phase
  function automatic logic line_scl(phase_t ph);
    logic lvl;
    case (ph)
      PH_START_C, PH_SEND_LOW, PH_ACK_LOW, PH_RECV_LOW,
      PH_NACK_LOW, PH_STOP_A: lvl = 1'b0;
      default:                lvl = 1'b1;
    endcase
    return lvl;
  endfunction

  // data line drive per phase, data bit used while a byte is sent
  function automatic logic line_sda(phase_t ph, logic data_bit);
    logic lvl;
    case (ph)
      PH_START_B, PH_START_C, PH_STOP_A, PH_STOP_B: lvl = 1'b0;
      PH_SEND_LOW, PH_SEND_HIGH:                    lvl = data_bit;
      default:                                      lvl = 1'b1;
    endcase
    return lvl;
  endfunction

endpackage
`default_nettype wire

// ===== src/ebm_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ebm_in_if
// Tick channel into the byte master: valid, ready and one input item.
// ----------------------------------------------------------------------------
interface ebm_in_if;
  logic              valid;
  logic              ready;
  ebm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/ebm_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ebm_out_if
// Result channel out of the byte master: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface ebm_out_if;
  logic               valid;
  logic               ready;
  ebm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/ebm_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ebm_cfg_if
// Register write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
interface ebm_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ebm_pkg::CFG_INDEX_BITS-1:0] index;
  logic [ebm_pkg::CFG_DATA_BITS-1:0]  wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ===== src/ebm_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ebm_cfg_regs
// Configuration registers, written one transaction at a time.
// ----------------------------------------------------------------------------
module ebm_cfg_regs (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ebm_cfg_if.sink    cfg_if,
  output ebm_pkg::cfg_t cfg
);

  ebm_pkg::cfg_t cfg_r;
  ebm_pkg::cfg_t cfg_nxt;

  // writes are always taken
  assign cfg_if.ready = 1'b1;
  assign cfg          = cfg_r;

  // register select
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      case (ebm_pkg::reg_index_t'(cfg_if.index))
        ebm_pkg::REG_DEVICE_ADDRESS:   cfg_nxt.device_address   = cfg_if.wdata[6:0];
        ebm_pkg::REG_QUARTER_TICKS:    cfg_nxt.quarter_ticks    = cfg_if.wdata[15:0];
        ebm_pkg::REG_ACK_TIMEOUT:      cfg_nxt.ack_timeout      = cfg_if.wdata[7:0];
        ebm_pkg::REG_WRITE_WAIT_TICKS: cfg_nxt.write_wait_ticks = cfg_if.wdata[23:0];
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address   <= ebm_pkg::DEVICE_ADDRESS_RST;
      cfg_r.quarter_ticks    <= ebm_pkg::QUARTER_TICKS_RST;
      cfg_r.ack_timeout      <= ebm_pkg::ACK_TIMEOUT_RST;
      cfg_r.write_wait_ticks <= ebm_pkg::WRITE_WAIT_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/ebm_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ebm_seq
// Bus sequencer: state registers and the single-pass next-state and line logic.
// ----------------------------------------------------------------------------
module ebm_seq #(
  parameter int WAIT_COUNTER_BITS = ebm_pkg::WAIT_COUNTER_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire ebm_pkg::in_item_t item,
  input  wire ebm_pkg::cfg_t     cfg,
  output ebm_pkg::out_item_t     result
);

  localparam int CW = WAIT_COUNTER_BITS;
  // counter maximum, held wide enough for any counter width in range
  localparam logic [32:0] CNT_MAX = (33'd1 << CW) - 33'd1;

  ebm_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]    bit_count_r, bit_count_nxt;
  logic [7:0]    shift_byte_r, shift_byte_nxt;
  logic [CW-1:0] delay_count_r, delay_count_nxt;
  logic [7:0]    poll_count_r, poll_count_nxt;
  logic [7:0]    received_byte_r, received_byte_nxt;
  logic          error_flag_r, error_flag_nxt;
  logic          is_read_r, is_read_nxt;
  logic [7:0]    held_address_r, held_address_nxt;
  logic [7:0]    held_data_r, held_data_nxt;
  logic [1:0]    stage_r, stage_nxt;

  logic [15:0]   quarter_eff;
  logic [32:0]   quarter_wide;
  logic [32:0]   wait_wide;
  logic [CW-1:0] slot_load;
  logic [CW-1:0] wait_load;
  logic [3:0]    bit_inc;
  logic [7:0]    recv_shift;
  logic          done;

  // delay loads, zero slot acts as one, oversize loads saturate
  assign quarter_eff  = (cfg.quarter_ticks == 16'd0) ? 16'd1 : cfg.quarter_ticks;
  assign quarter_wide = 33'(quarter_eff);
  assign wait_wide    = 33'(cfg.write_wait_ticks);
  assign slot_load    = (quarter_wide > CNT_MAX) ? CNT_MAX[CW-1:0] : quarter_wide[CW-1:0];
  assign wait_load    = (wait_wide > CNT_MAX) ? CNT_MAX[CW-1:0] : wait_wide[CW-1:0];

  assign bit_inc    = bit_count_r + 4'd1;
  assign recv_shift = {shift_byte_r[6:0], item.sda_in};

  // next state for one tick
  always_comb begin
    phase_nxt         = phase_r;
    bit_count_nxt     = bit_count_r;
    shift_byte_nxt    = shift_byte_r;
    delay_count_nxt   = delay_count_r;
    poll_count_nxt    = poll_count_r;
    received_byte_nxt = received_byte_r;
    error_flag_nxt    = error_flag_r;
    is_read_nxt       = is_read_r;
    held_address_nxt  = held_address_r;
    held_data_nxt     = held_data_r;
    stage_nxt         = stage_r;
    done              = 1'b0;

    if (phase_r == ebm_pkg::PH_IDLE) begin
      // new transaction, other opcodes leave the bus idle
      if (item.opcode == ebm_pkg::OP_WRITE || item.opcode == ebm_pkg::OP_READ) begin
        held_address_nxt = item.word_address;
        held_data_nxt    = item.write_data;
        is_read_nxt      = (item.opcode == ebm_pkg::OP_READ);
        error_flag_nxt   = 1'b0;
        poll_count_nxt   = 8'd0;
        stage_nxt        = ebm_pkg::STAGE_DEVICE;
        phase_nxt        = ebm_pkg::PH_START_A;
        delay_count_nxt  = slot_load;
      end
    end else if (phase_r == ebm_pkg::PH_ACK_HIGH) begin
      // acknowledge poll
      if (!item.sda_in) begin
        delay_count_nxt = slot_load;
        case (stage_r)
          ebm_pkg::STAGE_DEVICE: begin
            stage_nxt      = ebm_pkg::STAGE_WORD;
            shift_byte_nxt = held_address_r;
            bit_count_nxt  = 4'd0;
            phase_nxt      = ebm_pkg::PH_SEND_LOW;
          end
          ebm_pkg::STAGE_WORD: begin
            stage_nxt = ebm_pkg::STAGE_DATA;
            if (is_read_r) begin
              phase_nxt = ebm_pkg::PH_START_A;
            end else begin
              shift_byte_nxt = held_data_r;
              bit_count_nxt  = 4'd0;
              phase_nxt      = ebm_pkg::PH_SEND_LOW;
            end
          end
          default: begin
            if (is_read_r) begin
              stage_nxt      = ebm_pkg::STAGE_RECV;
              shift_byte_nxt = 8'd0;
              bit_count_nxt  = 4'd0;
              phase_nxt      = ebm_pkg::PH_RECV_LOW;
            end else begin
              phase_nxt = ebm_pkg::PH_STOP_A;
            end
          end
        endcase
      end else if (poll_count_r >= cfg.ack_timeout) begin
        error_flag_nxt  = 1'b1;
        phase_nxt       = ebm_pkg::PH_STOP_A;
        delay_count_nxt = slot_load;
      end else begin
        poll_count_nxt = poll_count_r + 8'd1;
      end
    end else if (delay_count_r > CW'(1)) begin
      // slot still running
      delay_count_nxt = delay_count_r - CW'(1);
    end else begin
      // end of slot
      delay_count_nxt = slot_load;
      case (phase_r)
        ebm_pkg::PH_START_A: phase_nxt = ebm_pkg::PH_START_B;
        ebm_pkg::PH_START_B: phase_nxt = ebm_pkg::PH_START_C;
        ebm_pkg::PH_START_C: begin
          shift_byte_nxt = {cfg.device_address, (stage_r != ebm_pkg::STAGE_DEVICE)};
          bit_count_nxt  = 4'd0;
          phase_nxt      = ebm_pkg::PH_SEND_LOW;
        end
        ebm_pkg::PH_SEND_LOW: phase_nxt = ebm_pkg::PH_SEND_HIGH;
        ebm_pkg::PH_SEND_HIGH: begin
          shift_byte_nxt = {shift_byte_r[6:0], 1'b0};
          bit_count_nxt  = bit_inc;
          phase_nxt      = (bit_inc >= ebm_pkg::BYTE_BITS) ? ebm_pkg::PH_ACK_LOW
                                                           : ebm_pkg::PH_SEND_LOW;
        end
        ebm_pkg::PH_ACK_LOW: begin
          // ack slot keeps the spent counter
          delay_count_nxt = delay_count_r;
          poll_count_nxt  = 8'd0;
          phase_nxt       = ebm_pkg::PH_ACK_HIGH;
        end
        ebm_pkg::PH_RECV_LOW: phase_nxt = ebm_pkg::PH_RECV_HIGH;
        ebm_pkg::PH_RECV_HIGH: begin
          shift_byte_nxt = recv_shift;
          bit_count_nxt  = bit_inc;
          if (bit_inc >= ebm_pkg::BYTE_BITS) begin
            received_byte_nxt = recv_shift;
            phase_nxt         = ebm_pkg::PH_NACK_LOW;
          end else begin
            phase_nxt = ebm_pkg::PH_RECV_LOW;
          end
        end
        ebm_pkg::PH_NACK_LOW:  phase_nxt = ebm_pkg::PH_NACK_HIGH;
        ebm_pkg::PH_NACK_HIGH: phase_nxt = ebm_pkg::PH_STOP_A;
        ebm_pkg::PH_STOP_A:    phase_nxt = ebm_pkg::PH_STOP_B;
        ebm_pkg::PH_STOP_B:    phase_nxt = ebm_pkg::PH_STOP_C;
        ebm_pkg::PH_STOP_C: begin
          if (!is_read_r && !error_flag_r && cfg.write_wait_ticks != 24'd0) begin
            phase_nxt       = ebm_pkg::PH_WAIT;
            delay_count_nxt = wait_load;
          end else begin
            delay_count_nxt = delay_count_r;
            phase_nxt       = ebm_pkg::PH_IDLE;
            done            = 1'b1;
          end
        end
        default: begin
          // end of the write cycle
          delay_count_nxt = delay_count_r;
          phase_nxt       = ebm_pkg::PH_IDLE;
          done            = 1'b1;
        end
      endcase
    end
  end

  // line levels and status after the tick
  always_comb begin
    result.scl       = ebm_pkg::line_scl(phase_nxt);
    result.sda_out   = ebm_pkg::line_sda(phase_nxt, shift_byte_nxt[7]);
    result.busy_res  = (phase_nxt != ebm_pkg::PH_IDLE);
    result.done_res  = done;
    result.read_data = received_byte_nxt;
    result.ack_error = error_flag_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= ebm_pkg::PH_IDLE;
      bit_count_r     <= 4'd0;
      shift_byte_r    <= 8'd0;
      delay_count_r   <= '0;
      poll_count_r    <= 8'd0;
      received_byte_r <= 8'd0;
      error_flag_r    <= 1'b0;
      is_read_r       <= 1'b0;
      held_address_r  <= 8'd0;
      held_data_r     <= 8'd0;
      stage_r         <= ebm_pkg::STAGE_DEVICE;
    end else if (step) begin
      phase_r         <= phase_nxt;
      bit_count_r     <= bit_count_nxt;
      shift_byte_r    <= shift_byte_nxt;
      delay_count_r   <= delay_count_nxt;
      poll_count_r    <= poll_count_nxt;
      received_byte_r <= received_byte_nxt;
      error_flag_r    <= error_flag_nxt;
      is_read_r       <= is_read_nxt;
      held_address_r  <= held_address_nxt;
      held_data_r     <= held_data_nxt;
      stage_r         <= stage_nxt;
    end
  end

  // bit counter never runs past one byte
  assert property (@(posedge clk) disable iff (!rst_n) bit_count_r <= ebm_pkg::BYTE_BITS)
    else $error("bit counter past one byte");

  // receive stage only exists in a read
  assert property (@(posedge clk) disable iff (!rst_n)
                   (stage_r == ebm_pkg::STAGE_RECV) |-> is_read_r)
    else $error("receive stage in a write transaction");

  // a finished transaction leaves the sequencer idle
  assert property (@(posedge clk) disable iff (!rst_n)
                   (step && done) |=> (phase_r == ebm_pkg::PH_IDLE))
    else $error("done without returning to idle");

  // a start from idle opens with the start condition
  assert property (@(posedge clk) disable iff (!rst_n)
                   (step && phase_r == ebm_pkg::PH_IDLE &&
                    (item.opcode == ebm_pkg::OP_WRITE || item.opcode == ebm_pkg::OP_READ))
                   |=> (phase_r == ebm_pkg::PH_START_A && stage_r == ebm_pkg::STAGE_DEVICE))
    else $error("start from idle did not begin a start condition");

endmodule
`default_nettype wire

// ===== src/ebm_out_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ebm_out_reg
// Result register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module ebm_out_reg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load_valid,
  input  wire ebm_pkg::out_item_t load_data,
  output logic                    load_ready,
  ebm_out_if.source               out_if
);

  logic               valid_r, valid_nxt;
  ebm_pkg::out_item_t data_r;

  // free when empty or when the held result leaves this cycle
  assign load_ready  = !valid_r || out_if.ready;
  assign valid_nxt   = load_ready ? load_valid : valid_r;
  assign out_if.valid = valid_r;
  assign out_if.data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload loads with each accepted tick
  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      data_r <= load_data;
    end
  end

endmodule
`default_nettype wire

// ===== src/i2c_eeprom_byte_master.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master
// Tick-driven bus master for byte writes and random reads of a serial EEPROM.
// ----------------------------------------------------------------------------
// Every input transaction is one bus tick and yields exactly one result
// transaction holding the clock and data line levels, busy, done, the last
// read byte and the ack error flag after that tick. A tick is taken every
// clock cycle and its result appears in the next cycle from the result
// register; the input stalls only while that register holds a result the
// sink has not taken. Bus timing is counted in ticks, not clock cycles: each
// line phase lasts quarter_ticks ticks, an ack is polled for up to
// ack_timeout high ticks, and a byte write ends with write_wait_ticks ticks
// of write cycle before done. The user must write registers only while no
// transaction is in progress (unenforced); the register port is always ready.
module i2c_eeprom_byte_master #(
  parameter int WAIT_COUNTER_BITS = ebm_pkg::WAIT_COUNTER_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ebm_in_if.sink    in_if,
  ebm_out_if.source out_if,
  ebm_cfg_if.sink   cfg_if
);

  ebm_pkg::cfg_t      cfg;
  ebm_pkg::out_item_t result;
  logic               load_ready;
  logic               step;

  // tick accepted whenever the result register can take its result
  assign in_if.ready = load_ready;
  assign step        = in_if.valid && load_ready;

  ebm_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  ebm_seq #(
    .WAIT_COUNTER_BITS (WAIT_COUNTER_BITS)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_if.data),
    .cfg    (cfg),
    .result (result)
  );

  ebm_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_if.valid),
    .load_data  (result),
    .load_ready (load_ready),
    .out_if     (out_if)
  );

endmodule
`default_nettype wire

// ===== test/tb_i2c_eeprom_byte_master.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_i2c_eeprom_byte_master
// Self-checking bench for the tick-driven serial EEPROM byte master.
// ----------------------------------------------------------------------------
// A bench-side model of the bus sequencer predicts the line levels and status
// of every tick. The sender plays the memory device, answering acks and
// supplying read bits from the predicted bus phase. Directed tests cover the
// field extremes, byte writes, random reads, ack polling limits, ack aborts in
// every byte, starts while busy and zero-length slots. Random byte writes and
// reads with random registers, noise ticks and random idling on both channels
// follow. Every result transaction is compared field by field.
module tb_i2c_eeprom_byte_master;
  import ebm_pkg::*;

  localparam logic [1:0] OP_SPARE     = 2'd3;
  localparam int         WAIT_BITS    = WAIT_COUNTER_BITS_DEF;
  localparam int         RANDOM_TICKS = 200;
  localparam int         CYCLE_LIMIT  = 3000000;

  logic clk = 1'b0;
  logic rst_n;

  ebm_in_if  in_if ();
  ebm_out_if out_if ();
  ebm_cfg_if cfg_if ();

  i2c_eeprom_byte_master i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // clock
  always #1 clk = ~clk;

  // register mirror and sequencer state of the bench model
  cfg_t                 regs;
  phase_t               ph;
  logic [3:0]           bit_cnt;
  logic [7:0]           shifter;
  logic [WAIT_BITS-1:0] slot_left;
  logic [7:0]           polls;
  logic [7:0]           rx_byte;
  logic                 err_flag;
  logic                 rd_txn;
  logic [7:0]           addr_hold;
  logic [7:0]           data_hold;
  logic [1:0]           byte_stage;

  out_item_t expected_lines[$];

  // run control and statistics
  int  failures          = 0;
  int  ticks_sent        = 0;
  int  results_checked   = 0;
  int  n_writes          = 0;
  int  n_reads           = 0;
  int  n_aborts          = 0;
  int  long_hold_cycles  = 0;
  int  busy_start_pct    = 10;
  bit  idle_on           = 1'b1;
  bit  sink_idle_on      = 1'b1;

  initial begin
    regs       = '{DEVICE_ADDRESS_RST, QUARTER_TICKS_RST, ACK_TIMEOUT_RST,
                   WRITE_WAIT_TICKS_RST};
    ph         = PH_IDLE;
    bit_cnt    = '0;
    shifter    = '0;
    slot_left  = '0;
    polls      = '0;
    rx_byte    = '0;
    err_flag   = 1'b0;
    rd_txn     = 1'b0;
    addr_hold  = '0;
    data_hold  = '0;
    byte_stage = STAGE_DEVICE;
  end

  // ---------------------------------------------------------------------------
  // bus sequencer model
  // ---------------------------------------------------------------------------

  // start a timed phase, a zero slot length counts as one tick
  function automatic void enter_phase(input phase_t p);
    ph        = p;
    slot_left = (regs.quarter_ticks == '0) ? WAIT_BITS'(1) : WAIT_BITS'(regs.quarter_ticks);
  endfunction

  function automatic void load_shift(input logic [7:0] b);
    shifter = b;
    bit_cnt = '0;
    enter_phase(PH_SEND_LOW);
  endfunction

  // next byte, repeated start, receive or stop once a byte is acked
  function automatic void ack_taken();
    if (byte_stage == STAGE_DEVICE) begin
      byte_stage = STAGE_WORD;
      load_shift(addr_hold);
    end else if (byte_stage == STAGE_WORD) begin
      byte_stage = STAGE_DATA;
      if (rd_txn) enter_phase(PH_START_A);
      else load_shift(data_hold);
    end else if (rd_txn) begin
      byte_stage = STAGE_RECV;
      shifter    = '0;
      bit_cnt    = '0;
      enter_phase(PH_RECV_LOW);
    end else begin
      enter_phase(PH_STOP_A);
    end
  endfunction

  // one bus tick: advance the model and return the levels after it
  function automatic out_item_t bus_tick(input in_item_t it);
    out_item_t lv;
    logic      done;
    done = 1'b0;
    if (ph == PH_IDLE) begin
      if (it.opcode == OP_WRITE || it.opcode == OP_READ) begin
        addr_hold  = it.word_address;
        data_hold  = it.write_data;
        rd_txn     = (it.opcode == OP_READ);
        err_flag   = 1'b0;
        polls      = '0;
        byte_stage = STAGE_DEVICE;
        enter_phase(PH_START_A);
      end
    end else if (ph == PH_ACK_HIGH) begin
      // ack polling: low acks at once, too many highs abort with stop
      if (!it.sda_in) begin
        ack_taken();
      end else if (polls >= regs.ack_timeout) begin
        err_flag = 1'b1;
        enter_phase(PH_STOP_A);
      end else begin
        polls++;
      end
    end else if (slot_left > 1) begin
      slot_left--;
    end else begin
      case (ph)
        PH_START_A: enter_phase(PH_START_B);
        PH_START_B: enter_phase(PH_START_C);
        PH_START_C: load_shift({regs.device_address, byte_stage != STAGE_DEVICE});
        PH_SEND_LOW: enter_phase(PH_SEND_HIGH);
        PH_SEND_HIGH: begin
          shifter = shifter << 1;
          bit_cnt++;
          if (bit_cnt >= BYTE_BITS) enter_phase(PH_ACK_LOW);
          else enter_phase(PH_SEND_LOW);
        end
        PH_ACK_LOW: begin
          polls = '0;
          ph    = PH_ACK_HIGH;
        end
        PH_RECV_LOW: enter_phase(PH_RECV_HIGH);
        PH_RECV_HIGH: begin
          // sample on the last tick of the high slot
          shifter = {shifter[6:0], it.sda_in};
          bit_cnt++;
          if (bit_cnt >= BYTE_BITS) begin
            rx_byte = shifter;
            enter_phase(PH_NACK_LOW);
          end else begin
            enter_phase(PH_RECV_LOW);
          end
        end
        PH_NACK_LOW: enter_phase(PH_NACK_HIGH);
        PH_NACK_HIGH: enter_phase(PH_STOP_A);
        PH_STOP_A: enter_phase(PH_STOP_B);
        PH_STOP_B: enter_phase(PH_STOP_C);
        PH_STOP_C: begin
          if (!rd_txn && !err_flag && regs.write_wait_ticks != '0) begin
            ph        = PH_WAIT;
            slot_left = WAIT_BITS'(regs.write_wait_ticks);
          end else begin
            ph   = PH_IDLE;
            done = 1'b1;
          end
        end
        default: begin
          ph   = PH_IDLE;
          done = 1'b1;
        end
      endcase
    end

    // line levels of the phase reached
    case (ph)
      PH_START_C, PH_SEND_LOW, PH_ACK_LOW, PH_RECV_LOW, PH_NACK_LOW, PH_STOP_A:
        lv.scl = 1'b0;
      default: lv.scl = 1'b1;
    endcase
    case (ph)
      PH_START_B, PH_START_C, PH_STOP_A, PH_STOP_B: lv.sda_out = 1'b0;
      PH_SEND_LOW, PH_SEND_HIGH:                    lv.sda_out = shifter[7];
      default:                                      lv.sda_out = 1'b1;
    endcase
    lv.busy_res  = (ph != PH_IDLE);
    lv.done_res  = done;
    lv.read_data = rx_byte;
    lv.ack_error = err_flag;
    return lv;
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one tick transaction, predicted at the edge that takes it
  task automatic send_tick(input in_item_t it);
    int gap;
    gap = (idle_on && $urandom_range(0, 99) < 25) ? idle_len() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    expected_lines.push_back(bus_tick(it));
    ticks_sent++;
  endtask

  // register write once the bus is quiet and every result is in
  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
    in_if.valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_DEVICE_ADDRESS:   regs.device_address   = val[6:0];
      REG_QUARTER_TICKS:    regs.quarter_ticks    = val[15:0];
      REG_ACK_TIMEOUT:      regs.ack_timeout      = val[7:0];
      REG_WRITE_WAIT_TICKS: regs.write_wait_ticks = val[23:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [6:0] dev, input logic [15:0] quarter,
                          input logic [7:0] timeout, input logic [23:0] wait_ticks);
    write_reg(REG_DEVICE_ADDRESS, CFG_DATA_BITS'(dev));
    write_reg(REG_QUARTER_TICKS, CFG_DATA_BITS'(quarter));
    write_reg(REG_ACK_TIMEOUT, CFG_DATA_BITS'(timeout));
    write_reg(REG_WRITE_WAIT_TICKS, CFG_DATA_BITS'(wait_ticks));
  endtask

  // plain or spare-opcode tick with random content
  task automatic noise_tick();
    in_item_t it;
    it.opcode       = $urandom_range(0, 1) ? OP_TICK : OP_SPARE;
    it.word_address = 8'($urandom_range(0, 255));
    it.write_data   = 8'($urandom_range(0, 255));
    it.sda_in       = 1'($urandom_range(0, 1));
    send_tick(it);
  endtask

  // one byte write or random read from start to idle, the bench acting as the
  // memory device: ack number fail_ack never comes, the first ack comes after
  // ack_highs high polls (random when negative), the others after a random few
  task automatic bus_transaction(input logic [1:0] op, input logic [7:0] word,
                                 input logic [7:0] wbyte, input logic [7:0] slave_byte,
                                 input int fail_ack, input int ack_highs);
    in_item_t it;
    int       ack_no;
    int       highs_now;
    int       highs_goal;
    int       cap;
    logic     in_ack;
    ack_no     = 0;
    highs_now  = 0;
    highs_goal = 0;
    in_ack     = 1'b0;
    it.opcode       = op;
    it.word_address = word;
    it.write_data   = wbyte;
    it.sda_in       = 1'($urandom_range(0, 1));
    send_tick(it);
    while (ph != PH_IDLE) begin
      it.opcode       = ($urandom_range(0, 99) < busy_start_pct) ?
                        2'($urandom_range(0, 3)) : OP_TICK;
      it.word_address = 8'($urandom_range(0, 255));
      it.write_data   = 8'($urandom_range(0, 255));
      it.sda_in       = 1'($urandom_range(0, 1));
      if (ph == PH_ACK_HIGH) begin
        if (!in_ack) begin
          in_ack    = 1'b1;
          highs_now = 0;
          cap       = (regs.ack_timeout < 3) ? int'(regs.ack_timeout) : 3;
          if (ack_no == fail_ack) highs_goal = 1000;
          else if (ack_highs >= 0 && ack_no == 0) highs_goal = ack_highs;
          else highs_goal = $urandom_range(0, cap);
        end
        it.sda_in = (highs_now < highs_goal);
        if (it.sda_in) highs_now++;
      end else begin
        if (in_ack) begin
          in_ack = 1'b0;
          ack_no++;
        end
        // device data bit held over both halves of the bit
        if (ph == PH_RECV_LOW || ph == PH_RECV_HIGH) it.sda_in = slave_byte[4'd7 - bit_cnt];
      end
      send_tick(it);
    end
    if (op == OP_WRITE) n_writes++;
    else n_reads++;
    if (err_flag) n_aborts++;
  endtask

  // result sink: random stalls plus one long hold on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_cycles != 0) begin
        stall_left       = long_hold_cycles;
        long_hold_cycles = 0;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (sink_idle_on && $urandom_range(0, 99) < 20) stall_left = idle_len();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_lines.size() == 0) begin
        $error("result transaction with no tick waiting for it");
        failures++;
      end else begin
        want = expected_lines.pop_front();
        check_field("scl", 8'(want.scl), 8'(out_if.data.scl));
        check_field("sda_out", 8'(want.sda_out), 8'(out_if.data.sda_out));
        check_field("busy_res", 8'(want.busy_res), 8'(out_if.data.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(out_if.data.done_res));
        check_field("read_data", want.read_data, out_if.data.read_data);
        check_field("ack_error", 8'(want.ack_error), 8'(out_if.data.ack_error));
        results_checked++;
      end
    end
  end

  // run limit
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // idle bus at reset values, spare opcode acts as a plain tick
  task automatic test_idle_ticks();
    repeat (6) noise_tick();
  endtask

  task automatic test_byte_write();
    set_regs(7'd127, 16'd1, 8'd1, 24'd0);
    // no write wait: done on the last stop tick
    bus_transaction(OP_WRITE, 8'h00, 8'hFF, 8'h00, -1, 0);
    // first ack after exactly as many high polls as allowed
    bus_transaction(OP_WRITE, 8'hFF, 8'h00, 8'h00, -1, 1);
    write_reg(REG_WRITE_WAIT_TICKS, CFG_DATA_BITS'(5));
    bus_transaction(OP_WRITE, 8'h5A, 8'hA5, 8'h00, -1, -1);
  endtask

  task automatic test_random_read();
    // zero slot length runs as one tick
    set_regs(7'd0, 16'd0, 8'd2, 24'd3);
    bus_transaction(OP_READ, 8'hFF, 8'h00, 8'h00, -1, -1);
    bus_transaction(OP_READ, 8'h3C, 8'h12, 8'hA5, -1, -1);
  endtask

  // abort in each byte; read_data holds, no write wait follows
  task automatic test_ack_timeout();
    int k;
    set_regs(7'h2A, 16'd1, 8'd1, 24'hFFFFFF);
    bus_transaction(OP_READ, 8'h81, 8'h00, 8'h3C, -1, -1);
    for (k = 0; k < 3; k++) begin
      bus_transaction(OP_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'h00, k, -1);
      bus_transaction(OP_READ, 8'($urandom_range(0, 255)), 8'h00, 8'h66, k, -1);
    end
    bus_transaction(OP_READ, 8'h7E, 8'h00, 8'hC3, -1, -1);
  endtask

  // longest allowed poll run still acks
  task automatic test_ack_poll_limit();
    set_regs(7'h55, 16'd1, 8'd255, 24'd0);
    bus_transaction(OP_WRITE, 8'h11, 8'h22, 8'h00, -1, 255);
  endtask

  // every busy tick carries a random opcode, starts among them
  task automatic test_start_while_busy();
    set_regs(7'h1B, 16'd1, 8'd3, 24'd4);
    busy_start_pct = 100;
    bus_transaction(OP_WRITE, 8'hC0, 8'h0F, 8'h00, -1, -1);
    bus_transaction(OP_READ, 8'h0C, 8'hF0, 8'h96, -1, -1);
    busy_start_pct = 10;
  endtask

  task automatic test_slow_slots();
    set_regs(7'h50, 16'd3, 8'd3, 24'd50);
    bus_transaction(OP_READ, 8'h9A, 8'h00, 8'h5B, -1, -1);
  endtask

  // register extremes, exercised on the idle bus
  task automatic test_config_extremes();
    set_regs(7'd127, 16'd65535, 8'd255, 24'hFFFFFF);
    repeat (4) noise_tick();
    set_regs(7'd0, 16'd0, 8'd1, 24'd0);
    repeat (4) noise_tick();
  endtask

  // result sink holds off while ticks keep coming, so the input stalls
  task automatic test_backpressure();
    set_regs(7'h3F, 16'd2, 8'd3, 24'd10);
    idle_on          = 1'b0;
    long_hold_cycles = 300;
    bus_transaction(OP_WRITE, 8'hA0, 8'h5F, 8'h00, -1, -1);
    idle_on = 1'b1;
  endtask

  task automatic random_regs();
    int             r;
    logic [15:0]    quarter;
    logic [7:0]     timeout;
    logic [23:0]    wait_ticks;
    r = $urandom_range(0, 99);
    if (r < 10) quarter = 16'd0;
    else if (r < 70) quarter = 16'd1;
    else if (r < 90) quarter = 16'd2;
    else quarter = 16'($urandom_range(3, 6));
    timeout = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(1, 4)) :
              8'($urandom_range(5, 255));
    r = $urandom_range(0, 99);
    if (r < 20) wait_ticks = 24'd0;
    else if (r < 90) wait_ticks = 24'($urandom_range(1, 30));
    else wait_ticks = 24'($urandom_range(100, 400));
    set_regs(7'($urandom_range(0, 127)), quarter, timeout, wait_ticks);
  endtask

  // random writes and reads with random content, some acks withheld
  task automatic test_random_traffic();
    int txn_ticks;
    int first;
    int until_cfg;
    txn_ticks = 0;
    until_cfg = 0;
    while (txn_ticks < RANDOM_TICKS) begin
      if (until_cfg == 0) begin
        random_regs();
        until_cfg = $urandom_range(3, 6);
      end
      until_cfg--;
      idle_on      = ($urandom_range(0, 99) < 80);
      sink_idle_on = ($urandom_range(0, 99) < 80);
      repeat ($urandom_range(0, 3)) noise_tick();
      first = ticks_sent;
      bus_transaction($urandom_range(0, 1) ? OP_WRITE : OP_READ,
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)),
                      ($urandom_range(0, 99) < 15) ? $urandom_range(0, 2) : -1, -1);
      txn_ticks += ticks_sent - first;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    int w;
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_DEVICE_ADDRESS;
    cfg_if.wdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_byte_write();
    test_random_read();
    test_ack_timeout();
    test_ack_poll_limit();
    test_start_while_busy();
    test_slow_slots();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();

    // drain
    in_if.valid <= 1'b0;
    for (w = 0; w < 2000 && expected_lines.size() != 0; w++) @(posedge clk);
    if (expected_lines.size() != 0) begin
      $error("%0d result transactions never arrived", expected_lines.size());
      failures++;
    end
    repeat (20) @(posedge clk);

    $display("%0d bus ticks driven, %0d results compared", ticks_sent, results_checked);
    $display("%0d byte writes and %0d random reads, %0d ended on an ack timeout",
             n_writes, n_reads, n_aborts);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
